### sv/assert_macros.svh
// Assertion macros used by the checker file of the packetizer.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is low.
`define DMXDGP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmxdgp assertion failed");

// Clocked property that also holds during reset.
`define DMXDGP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dmxdgp reset assertion failed");

`endif

### sv/dmxdgp_pkg.sv
// Package of the DMX delta group packetizer: sizes, field widths, register
// indexes, reset values and the sequencer state type. No dependencies.
package dmxdgp_pkg;

  localparam int unsigned BYTES_PER_GROUP = 16;
  localparam int unsigned MAX_GROUPS      = 32;

  // Field widths of the stream items and registers.
  localparam int unsigned CH_IDX_W = 9;
  localparam int unsigned CH_VAL_W = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned GCNT_W   = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BPOS_W   = 5;
  localparam int unsigned SEQ_W    = 8;

  localparam int unsigned POS_W        = $clog2(BYTES_PER_GROUP);
  localparam int unsigned GRP_W        = CH_IDX_W - POS_W;
  localparam int unsigned SHADOW_DEPTH = MAX_GROUPS * BYTES_PER_GROUP;
  localparam int unsigned SHADOW_AW    = $clog2(SHADOW_DEPTH);
  localparam int unsigned PKT_LEN      = BYTES_PER_GROUP + 2;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE  = 1'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [GCNT_W-1:0]   GROUPS_RST = 6'd32;
  localparam logic [GCNT_W-1:0]   GROUPS_MAX = GCNT_W'(MAX_GROUPS);

  // Input kind carried in tuser.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

endpackage

### sv/dmx_delta_group_packetizer_core.sv
// Top level of the DMX delta group packetizer: shadow compare, refresh timer
// and packet sequencer. Depends on dmxdgp_pkg and dmxdgp_ram.
//
// Channel   Dir  Ports                        Carries
// s_axis    in   tvalid/tready/tdata/tuser     channel byte or 1 ms tick
// m_axis    out  tvalid/tready/tdata/tlast     one packet byte per transaction
// cfg       in   valid/ready/index/data        register write
//
// Cycles: a tick takes 1 cycle, a channel byte 2 (shadow RAM read, then
// compare and write back on the same RAM). A group end that sends adds 18
// output cycles, one byte per cycle while m_axis_tready_i stays high.
// Reset: after rst_ni rises the shadow RAM is cleared in 512 cycles; no
// input transaction is taken then, config writes are.
// Stalls: input is held off while a packet streams; the last byte waits in
// the output register while the next input is taken.
module dmx_delta_group_packetizer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: [8:0] channel_index, [16:9] channel_value, [23:17] zero
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [dmxdgp_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // tuser: [0] req_type
  input  logic                                  s_axis_tuser_i,
  // tdata: [7:0] packet_byte, [12:8] byte_position, [15:13] zero
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [dmxdgp_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dmxdgp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dmxdgp_pkg::PERIOD_W-1:0]       cfg_data_i
);

  localparam int unsigned IW  = dmxdgp_pkg::CH_IDX_W;
  localparam int unsigned VW  = dmxdgp_pkg::CH_VAL_W;
  localparam int unsigned PW  = dmxdgp_pkg::POS_W;
  localparam int unsigned GW  = dmxdgp_pkg::GRP_W;
  localparam int unsigned NW  = dmxdgp_pkg::GCNT_W;
  localparam int unsigned TW  = dmxdgp_pkg::PERIOD_W;
  localparam int unsigned AW  = dmxdgp_pkg::SHADOW_AW;
  localparam int unsigned BW  = dmxdgp_pkg::BYTE_W;
  localparam int unsigned EW  = dmxdgp_pkg::BPOS_W;
  localparam int unsigned SW  = dmxdgp_pkg::SEQ_W;

  // ---------------------------------------------------------------- state
  dmxdgp_pkg::state_e state_q, state_d;

  logic [TW-1:0] period_q;
  logic [NW-1:0] groups_q;
  logic [TW-1:0] tick_q, tick_d;
  logic          pending_q, pending_d;
  logic          active_q, active_d;
  logic          changed_q, changed_d;
  logic [SW-1:0] seq_q, seq_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [EW-1:0] emit_q, emit_d;

  // Item held between lookup and update.
  logic [IW-1:0] idx_q, idx_d;
  logic [VW-1:0] val_q, val_d;

  // Output register.
  logic          m_valid_q, m_valid_d;
  logic [BW-1:0] m_byte_q, m_byte_d;
  logic [EW-1:0] m_pos_q, m_pos_d;
  logic          m_last_q, m_last_d;

  // ---------------------------------------------------------------- input decode
  logic [IW-1:0] s_idx;
  logic [VW-1:0] s_val;
  logic [NW-1:0] eff_groups;
  logic          s_in_range;

  assign s_idx  = s_axis_tdata_i[IW-1:0];
  assign s_val  = s_axis_tdata_i[IW+VW-1:IW];

  // Group count clamped to 1..MAX_GROUPS.
  always_comb begin
    if (groups_q == '0) begin
      eff_groups = NW'(1);
    end else if (groups_q > dmxdgp_pkg::GROUPS_MAX) begin
      eff_groups = dmxdgp_pkg::GROUPS_MAX;
    end else begin
      eff_groups = groups_q;
    end
  end

  assign s_in_range = {{(NW-GW){1'b0}}, s_idx[IW-1:PW]} < eff_groups;

  // ---------------------------------------------------------------- memories
  logic          sh_we, sh_re;
  logic [AW-1:0] sh_waddr, sh_raddr;
  logic [VW-1:0] sh_wdata, sh_rdata;

  logic          gb_we, gb_re;
  logic [PW-1:0] gb_waddr, gb_raddr;
  logic [VW-1:0] gb_rdata;

  dmxdgp_ram #(
    .WIDTH (VW),
    .DEPTH (dmxdgp_pkg::SHADOW_DEPTH)
  ) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .re_i    (sh_re),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

  // Group buffer: written as bytes arrive, read back while the packet streams.
  dmxdgp_ram #(
    .WIDTH (VW),
    .DEPTH (dmxdgp_pkg::BYTES_PER_GROUP)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (gb_we),
    .waddr_i (gb_waddr),
    .wdata_i (s_val),
    .re_i    (gb_re),
    .raddr_i (gb_raddr),
    .rdata_o (gb_rdata)
  );

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= dmxdgp_pkg::PERIOD_RST;
      groups_q <= dmxdgp_pkg::GROUPS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dmxdgp_pkg::REG_REFRESH_PERIOD: period_q <= cfg_data_i;
        dmxdgp_pkg::REG_GROUPS_IN_USE:  groups_q <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic [TW:0]   tick_next;
  logic          differ;
  logic          chg;
  logic          act;
  logic          grp_end;
  logic [GW-1:0] grp_q;
  logic          emit_load;
  logic [EW-1:0] emit_dec;

  assign tick_next = {1'b0, tick_q} + (TW+1)'(1);
  assign differ    = sh_rdata != val_q;
  assign chg       = changed_q || differ;
  assign grp_q     = idx_q[IW-1:PW];
  assign grp_end   = idx_q[PW-1:0] == PW'(dmxdgp_pkg::BYTES_PER_GROUP - 1);
  assign act       = (grp_q == '0) ? pending_q : active_q;
  assign emit_load = !m_valid_q || m_axis_tready_i;
  assign emit_dec  = emit_q - EW'(1);

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    pending_d = pending_q;
    active_d  = active_q;
    changed_d = changed_q;
    seq_d     = seq_q;
    clr_d     = clr_q;
    emit_d    = emit_q;
    idx_d     = idx_q;
    val_d     = val_q;
    m_valid_d = m_valid_q;
    m_byte_d  = m_byte_q;
    m_pos_d   = m_pos_q;
    m_last_d  = m_last_q;

    s_axis_tready_o = 1'b0;
    sh_we    = 1'b0;
    sh_waddr = idx_q[AW-1:0];
    sh_wdata = val_q;
    sh_re    = 1'b0;
    sh_raddr = s_idx[AW-1:0];
    gb_we    = 1'b0;
    gb_waddr = s_idx[PW-1:0];
    gb_re    = 1'b0;
    gb_raddr = emit_dec[PW-1:0];

    // Output register drains on its own outside packet streaming.
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      dmxdgp_pkg::ST_CLEAR: begin
        sh_we    = 1'b1;
        sh_waddr = clr_q;
        sh_wdata = '0;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(dmxdgp_pkg::SHADOW_DEPTH - 1)) begin
          state_d = dmxdgp_pkg::ST_IDLE;
        end
      end

      dmxdgp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == dmxdgp_pkg::REQ_TICK) begin
            if (tick_next >= {1'b0, period_q}) begin
              pending_d = 1'b1;
              tick_d    = '0;
            end else begin
              tick_d = tick_next[TW-1:0];
            end
          end else if (s_in_range) begin
            // Start shadow lookup; the buffer takes the byte now.
            sh_re   = 1'b1;
            gb_we   = 1'b1;
            idx_d   = s_idx;
            val_d   = s_val;
            state_d = dmxdgp_pkg::ST_LOOKUP;
          end
        end
      end

      dmxdgp_pkg::ST_LOOKUP: begin
        sh_we = differ;
        if (grp_end) begin
          if (grp_q == '0) begin
            pending_d = 1'b0;
          end
          changed_d = 1'b0;
          active_d  = ({{(NW-GW){1'b0}}, grp_q} == eff_groups - NW'(1)) ? 1'b0 : act;
          emit_d    = '0;
          state_d   = (chg || act) ? dmxdgp_pkg::ST_EMIT : dmxdgp_pkg::ST_IDLE;
        end else begin
          changed_d = chg;
          state_d   = dmxdgp_pkg::ST_IDLE;
        end
      end

      dmxdgp_pkg::ST_EMIT: begin
        if (emit_load) begin
          m_valid_d = 1'b1;
          m_pos_d   = emit_q;
          m_last_d  = emit_q == EW'(dmxdgp_pkg::PKT_LEN - 1);
          if (emit_q == '0) begin
            m_byte_d = {{(BW-GW){1'b0}}, grp_q};
          end else if (emit_q == EW'(1)) begin
            m_byte_d = seq_q;
          end else begin
            m_byte_d = gb_rdata;
          end
          // Prefetch the data byte needed one load later.
          gb_re  = (emit_q != '0) && (emit_q != EW'(dmxdgp_pkg::PKT_LEN - 1));
          emit_d = emit_q + EW'(1);
          if (emit_q == EW'(dmxdgp_pkg::PKT_LEN - 1)) begin
            seq_d   = seq_q + SW'(1);
            state_d = dmxdgp_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = dmxdgp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmxdgp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      pending_q <= 1'b0;
      active_q  <= 1'b0;
      changed_q <= 1'b0;
      seq_q     <= '0;
      clr_q     <= '0;
      emit_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      pending_q <= pending_d;
      active_q  <= active_d;
      changed_q <= changed_d;
      seq_q     <= seq_d;
      clr_q     <= clr_d;
      emit_q    <= emit_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    m_byte_q <= m_byte_d;
    m_pos_q  <= m_pos_d;
    m_last_q <= m_last_d;
  end

  // ---------------------------------------------------------------- outputs
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {{(dmxdgp_pkg::M_TDATA_W - EW - BW){1'b0}}, m_pos_q, m_byte_q};

endmodule

### sv/dmxdgp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmxdgp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dmxdgp_checker.sv
// Port-level checker for the packetizer top level, bound to it below.
// Depends on dmxdgp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmxdgp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [dmxdgp_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  // Nothing offered on the edge after a reset edge.
  `DMXDGP_ASSERT_RST(a_no_valid_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o)

  // Shadow clear keeps the input closed on the first edge after reset.
  `DMXDGP_ASSERT(a_closed_after_reset, clk_i, rst_ni, $rose(rst_ni) |-> !s_axis_tready_o)

  // Input stays closed while a packet is partly out.
  `DMXDGP_ASSERT(a_closed_mid_packet, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)

  // The last marker sits exactly on the final packet position.
  `DMXDGP_ASSERT(a_last_at_end, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[12:8] == 5'd17)))

  // A stalled output byte holds.
  `DMXDGP_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))

endmodule

bind dmx_delta_group_packetizer_core dmxdgp_checker u_checker (.*);
